// ===== src/utf8_to_utf16_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_defines.svh
// Assertion macros shared by the UTF-8 to UTF-16 decoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge while reset is low
`define U8U16_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// Check that a signal keeps its value into the cycle after a condition
`define U8U16_ASSERT_HOLD(label, clk, rst, cond, sig) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> $stable(sig)) \
    else $error("%m: value did not hold");
`else
`define U8U16_ASSERT(label, clk, rst, prop)
`define U8U16_ASSERT_HOLD(label, clk, rst, cond, sig)
`endif
`endif

// ===== src/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Word types and byte class codes shared by the decoder front and back.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Input word: one UTF-8 byte and its end-of-stream mark
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } byte_word_t;

  // Output word: one UTF-16 unit
  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
    logic        bom_found;
  } unit_word_t;

  // Byte class: number of continuation bytes a lead takes
  typedef logic [2:0] fol_t;

  localparam fol_t FOL_NONE  = 3'd0;
  localparam fol_t FOL_ONE   = 3'd1;
  localparam fol_t FOL_TWO   = 3'd2;
  localparam fol_t FOL_THREE = 3'd3;
  localparam fol_t FOL_FOUR  = 3'd4;
  localparam fol_t FOL_FIVE  = 3'd5;
  localparam fol_t FOL_STRAY = 3'd7;

  // Queue entry: classified byte
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    fol_t       fol;
  } q_entry_t;

  // Queue head as seen by the back engine
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  // Byte order mark and surrogate constants
  localparam logic [7:0]  BOM_B0    = 8'hEF;
  localparam logic [7:0]  BOM_B1    = 8'hBB;
  localparam logic [7:0]  BOM_B2    = 8'hBF;
  localparam logic [15:0] SURR_HI   = 16'hD800;
  localparam logic [15:0] SURR_LO   = 16'hDC00;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

endpackage

// ===== src/utf8_to_utf16_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 transcoder: a classifying input queue feeds a
// decode engine with a registered unit output.
//
//   channel | valid      | stall      | word
//   --------+------------+------------+---------------------------------------
//   bytes   | byte_valid | byte_stall | byte_word: byte_in, end_of_stream
//   units   | unit_valid | unit_stall | unit_word: code_unit, final_unit,
//           |            |            |            bom_found
//
// The decode engine takes one byte per cycle while the output is free; a
// four-byte sequence holds it while it emits the low surrogate. At stream
// end it checks for an open sequence and replays the held bytes of each
// lead it drops, then emits the terminator.
// Each byte passes a queue slot and the decode engine; its unit is registered.
// Reset is synchronous; no clearing pass follows.
// A unit_stall with a unit waiting freezes the engine; the queue of
// QUEUE_DEPTH words keeps taking bytes until it fills.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  u8u16_pkg::byte_word_t  byte_word,
  output logic                   unit_valid,
  input  logic                   unit_stall,
  output u8u16_pkg::unit_word_t  unit_word
);
  import u8u16_pkg::*;

  q_head_t head;
  logic    pop;

  // Accept and classify
  u8u16_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .head       (head),
    .pop        (pop)
  );

  // Decode and emit
  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_word  (unit_word)
  );

endmodule

// ===== src/u8u16_front.sv =====
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts UTF-8 bytes, classifies each one and holds it in a short queue.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_defines.svh"

module u8u16_front #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  u8u16_pkg::byte_word_t  byte_word,
  output u8u16_pkg::q_head_t     head,
  input  logic                   pop
);
  import u8u16_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic               push;

  // Sort a byte by the number of continuation bytes it opens
  function automatic fol_t classify(input logic [7:0] b);
    fol_t f;
    priority if (b[7] == 1'b0)          f = FOL_NONE;
    else if (b[7:5] == 3'b110)          f = FOL_ONE;
    else if (b[7:4] == 4'b1110)         f = FOL_TWO;
    else if (b[7:3] == 5'b11110)        f = FOL_THREE;
    else if (b[7:2] == 6'b111110)       f = FOL_FOUR;
    else if (b[7:1] == 7'b1111110)      f = FOL_FIVE;
    else                                f = FOL_STRAY;
    return f;
  endfunction

  // Advance a pointer with wrap at the queue depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Take a word while a slot is free
  assign byte_stall = (cnt == CNT_W'(DEPTH));
  assign push       = byte_valid && !byte_stall;

  // Present the oldest word
  assign head.valid = (cnt != '0);
  assign head.entry = slots[rd_ptr];

  // Track fill level
  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_next = cnt + CNT_W'(1);
      2'b01:   cnt_next = cnt - CNT_W'(1);
      default: cnt_next = cnt;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      cnt <= cnt_next;
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{data: byte_word.byte_in,
                         eos:  byte_word.end_of_stream,
                         fol:  classify(byte_word.byte_in)};
    end
  end

  `U8U16_ASSERT(a_pop_needs_word, clk, rst, pop |-> head.valid)
  `U8U16_ASSERT(a_empty_ptrs_meet, clk, rst, (cnt == '0) |-> (wr_ptr == rd_ptr))
  `U8U16_ASSERT(a_fill_steps_up, clk, rst, (push && !pop) |=> (cnt == $past(cnt) + CNT_W'(1)))

endmodule

// ===== src/u8u16_back.sv =====
// ----------------------------------------------------------------------------
// u8u16_back
// Decodes classified bytes into UTF-16 units, replays held bytes at stream
// end, and drives the registered unit output.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_defines.svh"

module u8u16_back (
  input  logic                   clk,
  input  logic                   rst,
  input  u8u16_pkg::q_head_t     head,
  output logic                   pop,
  output logic                   unit_valid,
  input  logic                   unit_stall,
  output u8u16_pkg::unit_word_t  unit_word
);
  import u8u16_pkg::*;

  // Engine states
  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_LOW    = 3'd1;
  localparam logic [2:0] ST_ROUND  = 3'd2;
  localparam logic [2:0] ST_REPLAY = 3'd3;
  localparam logic [2:0] ST_TERM   = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    fol_t       fol;
  } held_t;

  logic [2:0]  state, state_next;
  logic [2:0]  ret_state, ret_next;
  logic [7:0]  lead, lead_next;
  fol_t        lcls, lcls_next;
  logic [2:0]  need, need_next;
  logic [2:0]  hc, hc_next;
  logic        at_start, start_next;
  logic        bom_flag, bom_next;
  logic [9:0]  low_bits, low_next;
  logic [2:0]  rp_idx, rp_idx_next;
  logic [2:0]  rp_cnt, rp_cnt_next;
  held_t       held [4];

  logic        can_emit;
  logic        emit;
  unit_word_t  emit_word;
  logic        take_push;
  logic [2:0]  cont_state;
  logic        held_we;

  // Byte under decode
  logic [7:0]  src_data;
  fol_t        src_fol;

  // Outcome of decoding one byte
  logic        p_emit;
  logic [15:0] p_code;
  logic        p_pair;
  logic [9:0]  p_low;
  logic [7:0]  p_lead;
  fol_t        p_lcls;
  logic [2:0]  p_need;
  logic [2:0]  p_hc;
  logic        p_start;
  logic        p_bom;
  logic        p_we;
  logic [5:0]  t_bits, h0_bits, h1_bits;
  logic [20:0] supp;
  logic        is_bom;

  assign can_emit = !unit_valid || !unit_stall;

  // Pick the queue head in normal flow, a held byte during replay
  always_comb begin
    if (state == ST_REPLAY) begin
      src_data = held[rp_idx[1:0]].data;
      src_fol  = held[rp_idx[1:0]].fol;
    end else begin
      src_data = head.entry.data;
      src_fol  = head.entry.fol;
    end
  end

  assign t_bits  = src_data[5:0];
  assign h0_bits = held[0].data[5:0];
  assign h1_bits = held[1].data[5:0];
  assign supp    = {lead[2:0], h0_bits, h1_bits, t_bits} - SUPP_BASE;
  assign is_bom  = at_start && (lead == BOM_B0) && (held[0].data == BOM_B1)
                   && (src_data == BOM_B2);

  // Decode one byte against the open sequence
  always_comb begin
    p_emit  = 1'b0;
    p_code  = '0;
    p_pair  = 1'b0;
    p_low   = low_bits;
    p_lead  = lead;
    p_lcls  = lcls;
    p_need  = need;
    p_hc    = hc;
    p_start = at_start;
    p_bom   = bom_flag;
    p_we    = 1'b0;
    if (need == 3'd0) begin
      if (src_fol == FOL_NONE) begin
        p_emit  = 1'b1;
        p_code  = {8'h00, src_data};
        p_start = 1'b0;
      end else if (src_fol == FOL_STRAY) begin
        p_start = 1'b0;
      end else begin
        p_lead = src_data;
        p_lcls = src_fol;
        p_need = src_fol;
        p_hc   = '0;
      end
    end else if (need == 3'd1) begin
      // Close the sequence; four- and five-follower leads vanish here
      unique case (lcls)
        FOL_ONE: begin
          p_emit = 1'b1;
          p_code = {5'b00000, lead[4:0], t_bits};
        end
        FOL_TWO: begin
          if (is_bom) begin
            p_bom = 1'b1;
          end else begin
            p_emit = 1'b1;
            p_code = {lead[3:0], h0_bits, t_bits};
          end
        end
        FOL_THREE: begin
          p_emit = 1'b1;
          p_code = SURR_HI | {6'b000000, supp[19:10]};
          p_pair = 1'b1;
          p_low  = supp[9:0];
        end
        default: ;
      endcase
      p_start = 1'b0;
      p_lead  = '0;
      p_need  = '0;
      p_hc    = '0;
    end else begin
      // Hold a continuation byte
      if (!hc[2]) begin
        p_we = 1'b1;
        p_hc = hc + 3'd1;
      end
      p_need = need - 3'd1;
    end
  end

  // Sequence the engine
  always_comb begin
    state_next  = state;
    ret_next    = ret_state;
    lead_next   = lead;
    lcls_next   = lcls;
    need_next   = need;
    hc_next     = hc;
    start_next  = at_start;
    bom_next    = bom_flag;
    low_next    = low_bits;
    rp_idx_next = rp_idx;
    rp_cnt_next = rp_cnt;
    take_push   = 1'b0;
    cont_state  = ST_RUN;
    emit        = 1'b0;
    emit_word   = '{code_unit: '0, final_unit: 1'b0, bom_found: bom_flag};
    pop         = 1'b0;

    unique case (state)
      ST_RUN: begin
        if (head.valid && can_emit) begin
          take_push  = 1'b1;
          pop        = 1'b1;
          cont_state = head.entry.eos ? ST_ROUND : ST_RUN;
        end
      end
      ST_REPLAY: begin
        if (rp_idx == rp_cnt) begin
          state_next = ST_ROUND;
        end else if (can_emit) begin
          take_push   = 1'b1;
          cont_state  = ST_REPLAY;
          rp_idx_next = rp_idx + 3'd1;
        end
      end
      ST_ROUND: begin
        // Drop an open lead and replay what it held, or go on to the terminator
        if (need != 3'd0) begin
          rp_cnt_next = hc;
          rp_idx_next = '0;
          need_next   = '0;
          hc_next     = '0;
          lead_next   = '0;
          start_next  = 1'b0;
          state_next  = ST_REPLAY;
        end else begin
          state_next = ST_TERM;
        end
      end
      ST_LOW: begin
        if (can_emit) begin
          emit                = 1'b1;
          emit_word.code_unit = SURR_LO | {6'b000000, low_bits};
          state_next          = ret_state;
        end
      end
      ST_TERM: begin
        // Close the stream and return to the start-of-stream state
        if (can_emit) begin
          emit                 = 1'b1;
          emit_word.final_unit = 1'b1;
          lead_next            = '0;
          lcls_next            = FOL_NONE;
          need_next            = '0;
          hc_next              = '0;
          start_next           = 1'b1;
          bom_next             = 1'b0;
          state_next           = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase

    if (take_push) begin
      lead_next           = p_lead;
      lcls_next           = p_lcls;
      need_next           = p_need;
      hc_next             = p_hc;
      start_next          = p_start;
      bom_next            = p_bom;
      low_next            = p_low;
      emit                = p_emit;
      emit_word.code_unit = p_code;
      ret_next            = cont_state;
      state_next          = p_pair ? ST_LOW : cont_state;
    end
  end

  assign held_we = take_push && p_we;

  // Engine state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      ret_state <= ST_RUN;
      lead      <= '0;
      lcls      <= FOL_NONE;
      need      <= '0;
      hc        <= '0;
      at_start  <= 1'b1;
      bom_flag  <= 1'b0;
      rp_idx    <= '0;
      rp_cnt    <= '0;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
      lead      <= lead_next;
      lcls      <= lcls_next;
      need      <= need_next;
      hc        <= hc_next;
      at_start  <= start_next;
      bom_flag  <= bom_next;
      rp_idx    <= rp_idx_next;
      rp_cnt    <= rp_cnt_next;
    end
  end

  // Pending low surrogate and held bytes
  always_ff @(posedge clk) begin
    low_bits <= low_next;
    if (held_we) held[hc[1:0]] <= '{data: src_data, fol: src_fol};
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else if (emit) begin
      unit_valid <= 1'b1;
    end else if (!unit_stall) begin
      unit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) unit_word <= emit_word;
  end

  `U8U16_ASSERT(a_idle_holds_none, clk, rst, (need == 3'd0) |-> (hc == 3'd0))
  `U8U16_ASSERT(a_held_plus_need, clk, rst, (need != 3'd0) |-> ((4'(hc) + 4'(need)) == 4'(lcls)))
  `U8U16_ASSERT(a_term_restarts, clk, rst, (state == ST_TERM && can_emit) |=> (state == ST_RUN && at_start && !bom_flag))

endmodule

// ===== tb/tb_utf8_to_utf16_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_decoder
// Feeds UTF-8 byte streams into the decoder and checks every UTF-16 word that
// comes out against a behavioral decoder kept in a scoreboard. Directed
// streams cover the byte order mark, every lead class, the surrogate pair,
// swallowed and stray bytes and a stream cut inside a sequence; random streams
// follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_decoder;
  import u8u16_pkg::*;

  localparam int MAX_UNITS   = 6;
  localparam int STUCK_LIMIT = 1000;

  // Decoder of bytes into expected UTF-16 words, plus the word checker
  class unit_scoreboard;
    unit_word_t expected_units[$];
    int         errors;
    logic [7:0] lead;
    logic [2:0] need;
    logic [7:0] held[4];
    logic [2:0] held_cnt;
    logic       at_start;
    logic       bom;
    int         step_units;

    function new();
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      lead     = 8'h00;
      need     = 3'd0;
      held_cnt = 3'd0;
      at_start = 1'b1;
      bom      = 1'b0;
      foreach (held[i]) held[i] = 8'h00;
    endfunction

    function fol_t byte_class(logic [7:0] c);
      if (c < 8'h80) return FOL_NONE;
      if (c >= 8'hC0 && c <= 8'hDF) return FOL_ONE;
      if (c >= 8'hE0 && c <= 8'hEF) return FOL_TWO;
      if (c >= 8'hF0 && c <= 8'hF7) return FOL_THREE;
      if (c >= 8'hF8 && c <= 8'hFB) return FOL_FOUR;
      if (c >= 8'hFC && c <= 8'hFD) return FOL_FIVE;
      return FOL_STRAY;
    endfunction

    function void emit(logic [15:0] unit, logic fin);
      unit_word_t w;
      if (step_units < MAX_UNITS) begin
        w.code_unit  = unit;
        w.final_unit = fin;
        w.bom_found  = bom;
        expected_units.push_back(w);
        step_units++;
      end
    endfunction

    // Close the open sequence with its last byte
    function void finish_seq(logic [7:0] b);
      fol_t        k;
      logic [20:0] v;
      logic [5:0]  h0;
      logic [5:0]  h1;
      logic [5:0]  t;
      k  = byte_class(lead);
      h0 = held[0][5:0];
      h1 = held[1][5:0];
      t  = b[5:0];
      case (k)
        FOL_ONE: begin
          emit({5'b0, lead[4:0], t}, 1'b0);
        end
        FOL_TWO: begin
          if (at_start && lead == BOM_B0 && held[0] == BOM_B1 && b == BOM_B2)
            bom = 1'b1;
          else
            emit({lead[3:0], h0, t}, 1'b0);
        end
        FOL_THREE: begin
          v = {lead[2:0], h0, h1, t} - SUPP_BASE;
          emit(SURR_HI | {6'b0, v[19:10]}, 1'b0);
          emit(SURR_LO | {6'b0, v[9:0]}, 1'b0);
        end
        default: begin
          // longer leads swallow their bytes
        end
      endcase
      at_start = 1'b0;
      lead     = 8'h00;
      need     = 3'd0;
      held_cnt = 3'd0;
    endfunction

    function void decode_byte(logic [7:0] b);
      fol_t k;
      if (need == 3'd0) begin
        k = byte_class(b);
        if (k == FOL_NONE) begin
          emit({8'h00, b}, 1'b0);
          at_start = 1'b0;
        end else if (k == FOL_STRAY) begin
          at_start = 1'b0;
        end else begin
          lead     = b;
          need     = k;
          held_cnt = 3'd0;
        end
      end else if (need == 3'd1) begin
        finish_seq(b);
      end else begin
        if (held_cnt < 3'd4) begin
          held[held_cnt[1:0]] = b;
          held_cnt++;
        end
        need--;
      end
    endfunction

    // Note an accepted byte word and queue the units it completes
    function void note_byte(byte_word_t w);
      logic [7:0] tail[4];
      int         n;
      step_units = 0;
      decode_byte(w.byte_in);
      if (w.end_of_stream) begin
        // drop the open lead and decode its held bytes again
        while (need != 3'd0) begin
          n = (held_cnt > 3'd4) ? 4 : int'(held_cnt);
          for (int i = 0; i < 4; i++) tail[i] = held[i];
          lead     = 8'h00;
          need     = 3'd0;
          held_cnt = 3'd0;
          at_start = 1'b0;
          for (int i = 0; i < n; i++) decode_byte(tail[i]);
        end
        emit(16'h0000, 1'b1);
        clear_stream();
      end
    endfunction

    // Compare an accepted unit word with the oldest expectation
    function void check_unit(unit_word_t got);
      unit_word_t want;
      if (expected_units.size() == 0) begin
        $error("unexpected word: code_unit %h final_unit %b bom_found %b",
               got.code_unit, got.final_unit, got.bom_found);
        errors++;
      end else begin
        want = expected_units.pop_front();
        if (got.code_unit !== want.code_unit) begin
          $error("code_unit: expected %h, actual %h", want.code_unit, got.code_unit);
          errors++;
        end
        if (got.final_unit !== want.final_unit) begin
          $error("final_unit: expected %b, actual %b", want.final_unit, got.final_unit);
          errors++;
        end
        if (got.bom_found !== want.bom_found) begin
          $error("bom_found: expected %b, actual %b", want.bom_found, got.bom_found);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_word_t byte_word = '0;
  logic       unit_valid;
  logic       unit_stall = 1'b0;
  unit_word_t unit_word;

  unit_scoreboard sb;
  logic [7:0]     stream_bytes[$];
  int             bytes_sent = 0;
  int             stuck = 0;
  bit             calm = 1'b0;
  bit             paused_once = 1'b0;

  utf8_to_utf16_decoder uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_word  (unit_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the unit side at random, except in the calm stretch
  always @(posedge clk) begin
    unit_stall <= !calm && ($urandom_range(99) < 13);
  end

  // Note accepted words on both channels and count cycles with no progress
  always @(posedge clk) begin
    if (rst) begin
      stuck <= 0;
    end else begin
      if (byte_valid && !byte_stall) sb.note_byte(byte_word);
      if (unit_valid && !unit_stall) sb.check_unit(unit_word);
      if ((byte_valid && !byte_stall) || (unit_valid && !unit_stall))
        stuck <= 0;
      else
        stuck <= stuck + 1;
    end
  end

  initial begin
    while (stuck < STUCK_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Offer one byte word, with a random gap ahead, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic eos);
    calm = (bytes_sent >= 120 && bytes_sent < 190);
    while (!calm && $urandom_range(99) < 13) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid            <= 1'b1;
    byte_word.byte_in       <= b;
    byte_word.end_of_stream <= eos;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_bytes.size(); i++)
      send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    stream_bytes.delete();
  endtask

  // Hold the sender until every expected word has come back
  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_units.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] follower();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic void add_seq(logic [7:0] lead, int n_fol);
    stream_bytes.push_back(lead);
    repeat (n_fol) stream_bytes.push_back(follower());
  endfunction

  // Build a stream of mostly well-formed sequences with random content
  function automatic void build_stream(int n_seq);
    if ($urandom_range(4) == 0) begin
      stream_bytes.push_back(BOM_B0);
      stream_bytes.push_back(BOM_B1);
      stream_bytes.push_back(BOM_B2);
    end
    repeat (n_seq) begin
      case ($urandom_range(15))
        0, 1, 2:  add_seq(8'($urandom_range(127)), 0);
        3, 4:     add_seq({3'b110, 5'($urandom)}, 1);
        5, 6:     add_seq({4'b1110, 4'($urandom)}, 2);
        7, 8, 9:  add_seq({5'b11110, 3'($urandom)}, 3);
        10:       add_seq({6'b111110, 2'($urandom)}, 4);
        11:       add_seq({7'b1111110, 1'($urandom)}, 5);
        12:       add_seq(($urandom_range(3) == 0) ? {7'b1111111, 1'($urandom)}
                                                  : {2'b10, 6'($urandom)}, 0);
        13: begin
          stream_bytes.push_back(BOM_B0);
          stream_bytes.push_back(BOM_B1);
          stream_bytes.push_back(BOM_B2);
        end
        default:  add_seq(8'($urandom), 0);
      endcase
    end
    // cut the stream inside a sequence now and then
    if ($urandom_range(3) == 0)
      add_seq(8'($urandom_range(8'hC0, 8'hFD)), $urandom_range(3));
  endfunction

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // byte order mark, lead classes up to four followers, stray and swallowed bytes
    stream_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h00, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                     8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hF8, 8'h41, 8'h42, 8'h43,
                     8'h44, 8'h7F};
    send_stream();
    // stream ends inside a five-follower sequence: held bytes decode again
    stream_bytes = '{8'hFC, 8'h80, 8'h80, 8'hC1, 8'hFF};
    send_stream();
    wait_drained();

    while (bytes_sent < 270) begin
      build_stream($urandom_range(1, 12));
      send_stream();
      if (!paused_once && bytes_sent >= 220) begin
        wait_drained();
        paused_once = 1'b1;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
